FILE: src/mlwm_pkg.sv
package mlwm_pkg;

	localparam int MARKS_PER_SIDE = 3;
	localparam int LEVEL_WIDTH    = 16;
	localparam int PADDR_WIDTH    = 5;

	typedef logic [LEVEL_WIDTH-1:0] level_t;
	typedef logic [1:0]             mark_cnt_t;
	typedef logic signed [2:0]      pos_t;

	localparam pos_t POS_NONE = -3'sd1;

	typedef enum logic [2:0] {
		REG_HIGH_COUNT  = 3'd0,
		REG_HIGH_MARK_0 = 3'd1,
		REG_HIGH_MARK_1 = 3'd2,
		REG_HIGH_MARK_2 = 3'd3,
		REG_LOW_COUNT   = 3'd4,
		REG_LOW_MARK_0  = 3'd5,
		REG_LOW_MARK_1  = 3'd6,
		REG_LOW_MARK_2  = 3'd7
	} reg_idx_t;

	localparam logic SIDE_HIGH = 1'b0;
	localparam logic SIDE_LOW  = 1'b1;

	// Outcome of checking one count change against the marks
	typedef struct packed {
		logic      crossed;
		logic      mark_side;
		logic [1:0] mark_number;
		logic      pos_we;
		pos_t      high_pos;
		pos_t      low_pos;
	} eval_t;

endpackage

FILE: src/mlwm_eval.sv
module mlwm_eval import mlwm_pkg::*; (
	input  level_t    new_level,
	input  level_t    previous_level,
	input  mark_cnt_t high_count,
	input  level_t    high_mark [MARKS_PER_SIDE],
	input  mark_cnt_t low_count,
	input  level_t    low_mark [MARKS_PER_SIDE],
	input  pos_t      high_pos,
	input  pos_t      low_pos,
	output eval_t     result
);

	mark_cnt_t high_used;
	mark_cnt_t low_used;
	mark_cnt_t high_n;
	mark_cnt_t low_n;
	pos_t      high_idx;
	pos_t      low_idx;

	// Clamp the count of marks in use to the number of mark registers
	assign high_used = (int'(high_count) > MARKS_PER_SIDE) ? 2'(MARKS_PER_SIDE) : high_count;
	assign low_used  = (int'(low_count) > MARKS_PER_SIDE) ? 2'(MARKS_PER_SIDE) : low_count;

	always_comb begin
		high_n = '0;
		low_n  = '0;
		for (int i = 0; i < MARKS_PER_SIDE; i++) begin
			if (i < int'(high_used) && high_mark[i] <= new_level)
				high_n = high_n + 2'd1;
			if (i < int'(low_used) && low_mark[i] < new_level)
				low_n = low_n + 2'd1;
		end
	end

	assign high_idx = $signed({1'b0, high_n}) - 3'sd1;
	assign low_idx  = $signed({1'b0, low_n});

	always_comb begin
		result          = '0;
		result.high_pos = high_pos;
		result.low_pos  = low_pos;
		if (new_level < previous_level) begin
			// falling: nearest low mark at or above the count
			if (low_used != '0 && low_n < low_used && low_pos != low_idx) begin
				result.crossed     = 1'b1;
				result.mark_side   = SIDE_LOW;
				result.mark_number = low_n;
				result.pos_we      = 1'b1;
				result.high_pos    = low_idx - 3'sd1;
				result.low_pos     = low_idx;
			end
		end else if (high_used != '0) begin
			if (high_n == '0) begin
				// below every high mark: rearm the high side only
				result.pos_we   = 1'b1;
				result.high_pos = POS_NONE;
			end else if (high_pos != high_idx) begin
				result.crossed     = 1'b1;
				result.mark_side   = SIDE_HIGH;
				result.mark_number = high_idx[1:0];
				result.pos_we      = 1'b1;
				result.high_pos    = high_idx;
				result.low_pos     = high_idx + 3'sd1;
			end
		end
	end

endmodule

FILE: src/multi_level_watermark_monitor.sv
// Queue watermark monitor: each transaction on the input carries a new and a
// previous occupancy count and yields exactly one result transaction, which
// either reports a crossed mark (side, index within the side, count) or is
// all zeros. One transaction is taken every cycle while in_stall is low; a result
// passes through the input register and then the result register, with the
// combinational compare and position update between them. Any register write
// rearms both sides; write registers only while no transaction is in flight.
module multi_level_watermark_monitor import mlwm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PADDR_WIDTH-1:0] paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  level_t                 new_level,
	input  level_t                 previous_level,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   crossed,
	output logic                   mark_side,
	output logic [1:0]             mark_number,
	output level_t                 level_reported
);

	mark_cnt_t high_count_q;
	mark_cnt_t low_count_q;
	level_t    high_mark_q [MARKS_PER_SIDE];
	level_t    low_mark_q [MARKS_PER_SIDE];
	pos_t      high_pos_q;
	pos_t      low_pos_q;

	logic      valid_s1;
	level_t    new_level_s1;
	level_t    prev_level_s1;

	logic      crossed_q;
	logic      mark_side_q;
	logic [1:0] mark_number_q;
	level_t    level_q;

	logic      cfg_we;
	reg_idx_t  cfg_idx;
	logic      advance;
	eval_t     ev;

	assign pready  = 1'b1;
	assign cfg_we  = psel & penable & pwrite & pready;
	assign cfg_idx = reg_idx_t'(paddr[PADDR_WIDTH-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_count_q <= '0;
			low_count_q  <= '0;
			for (int i = 0; i < MARKS_PER_SIDE; i++) begin
				high_mark_q[i] <= '0;
				low_mark_q[i]  <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_HIGH_COUNT:  high_count_q   <= pwdata[1:0];
				REG_HIGH_MARK_0: high_mark_q[0] <= pwdata[LEVEL_WIDTH-1:0];
				REG_HIGH_MARK_1: high_mark_q[1] <= pwdata[LEVEL_WIDTH-1:0];
				REG_HIGH_MARK_2: high_mark_q[2] <= pwdata[LEVEL_WIDTH-1:0];
				REG_LOW_COUNT:   low_count_q    <= pwdata[1:0];
				REG_LOW_MARK_0:  low_mark_q[0]  <= pwdata[LEVEL_WIDTH-1:0];
				REG_LOW_MARK_1:  low_mark_q[1]  <= pwdata[LEVEL_WIDTH-1:0];
				REG_LOW_MARK_2:  low_mark_q[2]  <= pwdata[LEVEL_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			REG_HIGH_COUNT:  prdata = {30'd0, high_count_q};
			REG_HIGH_MARK_0: prdata = 32'(high_mark_q[0]);
			REG_HIGH_MARK_1: prdata = 32'(high_mark_q[1]);
			REG_HIGH_MARK_2: prdata = 32'(high_mark_q[2]);
			REG_LOW_COUNT:   prdata = {30'd0, low_count_q};
			REG_LOW_MARK_0:  prdata = 32'(low_mark_q[0]);
			REG_LOW_MARK_1:  prdata = 32'(low_mark_q[1]);
			REG_LOW_MARK_2:  prdata = 32'(low_mark_q[2]);
			default:         prdata = '0;
		endcase
	end

	// Stage 1 moves into the result register whenever that register frees up
	assign advance  = valid_s1 & (~out_valid | ~out_stall);
	assign in_stall = valid_s1 & ~advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			new_level_s1  <= new_level;
			prev_level_s1 <= previous_level;
		end
	end

	mlwm_eval u_eval (
		.new_level      (new_level_s1),
		.previous_level (prev_level_s1),
		.high_count     (high_count_q),
		.high_mark      (high_mark_q),
		.low_count      (low_count_q),
		.low_mark       (low_mark_q),
		.high_pos       (high_pos_q),
		.low_pos        (low_pos_q),
		.result         (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_pos_q <= POS_NONE;
			low_pos_q  <= POS_NONE;
		end else if (cfg_we) begin
			// rearm both sides on any register write
			high_pos_q <= POS_NONE;
			low_pos_q  <= POS_NONE;
		end else if (advance && ev.pos_we) begin
			high_pos_q <= ev.high_pos;
			low_pos_q  <= ev.low_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (advance)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			crossed_q     <= ev.crossed;
			mark_side_q   <= ev.mark_side;
			mark_number_q <= ev.mark_number;
			level_q       <= ev.crossed ? new_level_s1 : '0;
		end
	end

	assign crossed        = crossed_q;
	assign mark_side      = mark_side_q;
	assign mark_number    = mark_number_q;
	assign level_reported = level_q;

endmodule
